FILE: rtl/core/multi_stage_overcurrent_trip_unit_macros.svh
// Assertion macros shared by the overcurrent trip unit RTL.
`ifndef MULTI_STAGE_OVERCURRENT_TRIP_UNIT_MACROS_SVH
`define MULTI_STAGE_OVERCURRENT_TRIP_UNIT_MACROS_SVH

// Concurrent check on the rising clock, off during reset.
`define MSOT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen.
`define MSOT_NEVER(lbl, clk, rst, cond, msg) \
   `MSOT_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

FILE: rtl/core/msot_pkg.sv
// Shared types and constants of the overcurrent trip unit.
`default_nettype none

package msot_pkg;

   localparam int unsigned MaxStages   = 4;
   localparam int unsigned CurW        = 16;
   localparam int unsigned MagW        = CurW + 1;
   localparam int unsigned LeakW       = 8;
   localparam int unsigned CsrIndexW   = 3;
   localparam int unsigned CsrDataW    = 64;

   typedef enum logic {
      OP_CHECK = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_STAGE_COUNT  = 3'd0,
      CSR_THRESHOLDS   = 3'd1,
      CSR_TRIP_LIMITS  = 3'd2,
      CSR_LEAK_RATES   = 3'd3
   } csr_index_type;

   // Per-stage settings seen by one stage.
   typedef struct packed {
      logic [CurW-1:0]  threshold;
      logic [CurW-1:0]  trip_limit;
      logic [LeakW-1:0] leak_rate;
   } stage_cfg_type;

   // Per-stage update produced for one item.
   typedef struct packed {
      logic [CurW-1:0] bucket;
      logic            tripped;
      logic            fault;
      logic            halt;
   } stage_out_type;

endpackage

`default_nettype wire

FILE: rtl/core/multi_stage_overcurrent_trip_unit.sv
// An accepted req passes through the input register, then the result register, which
// drives rsp_valid; while rsp_stall holds the result, the item waits in the input register.
// Throughput: one item per cycle unless rsp_stall holds; all stages are evaluated in
// one pass of logic between the input register and the result register, which also
// updates the buckets. Reset (synchronous, active high) clears settings, buckets, trip
// flags and valids. Settings are written through the csr port, which is always ready.
`default_nettype none
`include "multi_stage_overcurrent_trip_unit_macros.svh"

module multi_stage_overcurrent_trip_unit
   import msot_pkg::*;
#(
   parameter int unsigned STAGES = 4
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // item in
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_operation,
   input  wire logic signed [CurW-1:0] req_current_sample,
   // item out
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_fault,
   output logic [MaxStages-1:0]       rsp_tripped_stages,
   // settings
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CsrIndexW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0]   csr_wdata
);

   localparam logic [2:0] StagesN = 3'(STAGES);

   // ---------------- settings ----------------
   logic [2:0]               stage_count_ff;
   logic [MaxStages*CurW-1:0]  thresholds_ff;
   logic [MaxStages*CurW-1:0]  trip_limits_ff;
   logic [MaxStages*LeakW-1:0] leak_rates_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_count_ff <= '0;
         thresholds_ff  <= '0;
         trip_limits_ff <= '0;
         leak_rates_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STAGE_COUNT: stage_count_ff <= csr_wdata[2:0];
            CSR_THRESHOLDS:  thresholds_ff  <= csr_wdata;
            CSR_TRIP_LIMITS: trip_limits_ff <= csr_wdata;
            CSR_LEAK_RATES:  leak_rates_ff  <= csr_wdata[MaxStages*LeakW-1:0];
            default: ; // unknown index: write dropped
         endcase
      end
   end

   // ---------------- input register ----------------
   logic            in_valid_ff;
   logic            in_op_ff;
   logic [CurW-1:0] in_sample_ff;
   logic            advance;   // compute stage moves its item into the result register

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_op_ff     <= req_operation;
         in_sample_ff <= req_current_sample;
      end
   end

   // ---------------- stage evaluation ----------------
   // Magnitude is 17 bits so the most negative sample reads as 32768.
   logic [MagW-1:0] magnitude;
   logic [2:0]      active_count;
   logic [CurW-1:0] bucket_ff [STAGES];
   logic [STAGES-1:0] tripped_ff;
   stage_out_type   stage_out [STAGES];
   logic [STAGES:0] run;          // no earlier instant trip
   logic [STAGES-1:0] stage_fault;
   logic [STAGES-1:0] tripped_next;

   assign magnitude    = in_sample_ff[CurW-1] ? MagW'(0) - {1'b1, in_sample_ff}
                                              : {1'b0, in_sample_ff};
   assign active_count = (stage_count_ff > StagesN) ? StagesN : stage_count_ff;
   assign run[0]       = 1'b1;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      stage_cfg_type cfg;
      logic          active;

      assign cfg.threshold  = thresholds_ff[CurW*i +: CurW];
      assign cfg.trip_limit = trip_limits_ff[CurW*i +: CurW];
      assign cfg.leak_rate  = leak_rates_ff[LeakW*i +: LeakW];
      assign active         = run[i] && (3'(i) < active_count);

      msot_stage u_stage (
         .active    (active),
         .magnitude (magnitude),
         .cfg       (cfg),
         .bucket    (bucket_ff[i]),
         .tripped   (tripped_ff[i]),
         .result    (stage_out[i])
      );

      assign run[i+1]        = run[i] && !stage_out[i].halt;
      assign stage_fault[i]  = stage_out[i].fault;
      assign tripped_next[i] = stage_out[i].tripped;
   end

   // ---------------- state and result registers ----------------
   logic                 fire;   // item leaves the input register this cycle
   logic                 rsp_valid_ff;
   logic                 rsp_fault_ff;
   logic [MaxStages-1:0] rsp_tripped_ff;

   assign fire = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         tripped_ff <= '0;
         for (int i = 0; i < STAGES; i++) begin
            bucket_ff[i] <= '0;
         end
      end else if (fire) begin
         if (in_op_ff == OP_CLEAR) begin
            tripped_ff <= '0;
            for (int i = 0; i < STAGES; i++) begin
               bucket_ff[i] <= '0;
            end
         end else begin
            tripped_ff <= tripped_next;
            for (int i = 0; i < STAGES; i++) begin
               bucket_ff[i] <= stage_out[i].bucket;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
      if (fire) begin
         if (in_op_ff == OP_CLEAR) begin
            rsp_fault_ff   <= 1'b0;
            rsp_tripped_ff <= '0;
         end else begin
            rsp_fault_ff   <= |stage_fault;
            rsp_tripped_ff <= MaxStages'(tripped_next);
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_fault          = rsp_fault_ff;
   assign rsp_tripped_stages = rsp_tripped_ff;

   // ---------------- checks ----------------
   `MSOT_ASSERT(a_clear_result, clock, reset,
      (fire && in_op_ff == OP_CLEAR) |=> (!rsp_fault && rsp_tripped_stages == '0),
      "clear item gave nonzero result")
   `MSOT_ASSERT(a_fault_has_flag, clock, reset,
      (rsp_valid && rsp_fault) |-> (rsp_tripped_stages != '0),
      "fault without a latched trip flag")
   `MSOT_ASSERT(a_flag_fall_on_clear, clock, reset,
      (|($past(tripped_ff) & ~tripped_ff)) |-> $past(fire && in_op_ff == OP_CLEAR),
      "trip flag dropped without clear")
   `MSOT_NEVER(a_stall_when_empty, clock, reset, !in_valid_ff && req_stall,
      "stall with empty input register")

endmodule

`default_nettype wire

FILE: rtl/core/msot_stage.sv
// One protection stage: threshold compare and leaky-bucket update.
`default_nettype none

module msot_stage
   import msot_pkg::*;
(
   input  wire logic            active,
   input  wire logic [MagW-1:0] magnitude,
   input  wire stage_cfg_type   cfg,
   input  wire logic [CurW-1:0] bucket,
   input  wire logic            tripped,
   output stage_out_type        result
);

   logic            above;
   logic [CurW-1:0] leak_ext;

   assign above    = magnitude > {1'b0, cfg.threshold};
   assign leak_ext = CurW'(cfg.leak_rate);

   always_comb begin
      result.bucket  = bucket;
      result.tripped = tripped;
      result.fault   = 1'b0;
      result.halt    = 1'b0;
      if (active) begin
         if (above) begin
            if (cfg.trip_limit == '0) begin
               // instant trip, later stages skipped
               result.tripped = 1'b1;
               result.fault   = 1'b1;
               result.halt    = 1'b1;
            end else if (bucket < cfg.trip_limit) begin
               result.bucket = bucket + CurW'(1);
            end else begin
               result.tripped = 1'b1;
               result.fault   = 1'b1;
            end
         end else if (bucket != '0 && !tripped) begin
            result.bucket = (bucket >= leak_ext) ? bucket - leak_ext : '0;
         end
      end
   end

endmodule

`default_nettype wire
